FILE: rtl/vgrc_pkg.sv
// ============================================================================
// vgrc_pkg
// Shared widths, codes and reset values of the video grid resize calculator.
// ============================================================================
`default_nettype none

package vgrc_pkg;

    localparam int F_W      = 11;   // spatial factor
    localparam int TF_W     = 5;    // temporal factor
    localparam int VOL_W    = 32;   // volume bounds
    localparam int N_W      = 13;   // frame count
    localparam int SIDE_W   = 14;   // input side
    localparam int OUT_W    = 16;   // output side
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_SIDE   = 16383;
    localparam int DEF_FRAME_CAP  = 4096;
    localparam int ASPECT_LIMIT   = 200;

    localparam logic [F_W-1:0]   RST_SPATIAL  = 11'd32;
    localparam logic [TF_W-1:0]  RST_TEMPORAL = 5'd2;
    localparam logic [VOL_W-1:0] RST_MIN_VOL  = 32'd3136;
    localparam logic [VOL_W-1:0] RST_MAX_VOL  = 32'd12845056;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPATIAL  = 2'd0,
        CFG_TEMPORAL = 2'd1,
        CFG_MIN_VOL  = 2'd2,
        CFG_MAX_VOL  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SMALL  = 2'd1,
        ST_ASPECT = 2'd2
    } t_status;

    // word riding along the first divider chain
    typedef struct packed {
        t_status             status;
        logic [N_W-1:0]      n;
        logic [SIDE_W-1:0]   h;
        logic [SIDE_W-1:0]   w;
    } t_head;

    // word in the multiply stages
    typedef struct packed {
        t_status             status;
        logic [N_W-1:0]      n;
        logic [SIDE_W-1:0]   h;
        logic [SIDE_W-1:0]   w;
        logic [14:0]         hr;
        logic [14:0]         wr;
        logic [13:0]         t;
        logic [OUT_W-1:0]    satv;
        logic [26:0]         nw;
        logic [26:0]         nh;
        logic [28:0]         th;
        logic [43:0]         vol;
        logic                shrink;
        logic                grow;
    } t_mid;

    // word riding along the rescale chains
    typedef struct packed {
        t_status             status;
        logic                shrink;
        logic                grow;
        logic [14:0]         hr;
        logic [14:0]         wr;
        logic [OUT_W-1:0]    satv;
    } t_tail;

endpackage

`default_nettype wire

FILE: rtl/vgrc_div_chain.sv
// ============================================================================
// vgrc_div_chain
// Row of restoring divider cells, one quotient bit per cell, several lanes.
// ============================================================================
`default_nettype none

module vgrc_div_chain #(
    parameter int LANES = 2,
    parameter int NW    = 16,
    parameter int DW    = 11,
    parameter int SW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num [LANES],
    input  logic [DW-1:0] i_den [LANES],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo [LANES],
    output logic [DW-1:0] o_rem [LANES],
    output logic [SW-1:0] o_side
);

    logic          r_v    [NW];
    logic [SW-1:0] r_side [NW];
    logic [NW-1:0] r_num  [NW][LANES];
    logic [DW-1:0] r_rem  [NW][LANES];
    logic [DW-1:0] r_den  [NW][LANES];

    for (genvar j = 0; j < NW; j++) begin : g_cell
        logic          c_v;
        logic [SW-1:0] c_side;
        logic [NW-1:0] c_num [LANES];
        logic [DW-1:0] c_rem [LANES];
        logic [DW-1:0] c_den [LANES];
        logic [NW-1:0] n_num [LANES];
        logic [DW-1:0] n_rem [LANES];

        if (j == 0) begin : g_first
            always_comb begin
                c_v    = i_valid;
                c_side = i_side;
                for (int l = 0; l < LANES; l++) begin
                    c_num[l] = i_num[l];
                    c_rem[l] = '0;
                    c_den[l] = i_den[l];
                end
            end
        end else begin : g_next
            always_comb begin
                c_v    = r_v[j-1];
                c_side = r_side[j-1];
                for (int l = 0; l < LANES; l++) begin
                    c_num[l] = r_num[j-1][l];
                    c_rem[l] = r_rem[j-1][l];
                    c_den[l] = r_den[j-1][l];
                end
            end
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            logic [DW:0] tr;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                tr       = {c_rem[l], c_num[l][NW-1]};
                ge       = (tr >= {1'b0, c_den[l]});
                n_rem[l] = ge ? DW'(tr - {1'b0, c_den[l]}) : tr[DW-1:0];
                n_num[l] = {c_num[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= c_side;
                for (int l = 0; l < LANES; l++) begin
                    r_num[j][l] <= n_num[l];
                    r_rem[j][l] <= n_rem[l];
                    r_den[j][l] <= c_den[l];
                end
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_side  = r_side[NW-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_num[NW-1][l];
            o_rem[l] = r_rem[NW-1][l];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/vgrc_sqrt_chain.sv
// ============================================================================
// vgrc_sqrt_chain
// Row of square root cells, one root bit per cell, several lanes.
// ============================================================================
`default_nettype none

module vgrc_sqrt_chain #(
    parameter int LANES = 2,
    parameter int RW    = 24,
    parameter int SW    = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad [LANES],
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root [LANES],
    output logic [RW+1:0]   o_rem  [LANES],
    output logic [SW-1:0]   o_side
);

    logic            r_v    [RW];
    logic [SW-1:0]   r_side [RW];
    logic [2*RW-1:0] r_rad  [RW][LANES];
    logic [RW+1:0]   r_rem  [RW][LANES];
    logic [RW-1:0]   r_root [RW][LANES];

    for (genvar j = 0; j < RW; j++) begin : g_cell
        logic            c_v;
        logic [SW-1:0]   c_side;
        logic [2*RW-1:0] c_rad  [LANES];
        logic [RW+1:0]   c_rem  [LANES];
        logic [RW-1:0]   c_root [LANES];
        logic [RW+1:0]   n_rem  [LANES];
        logic [RW-1:0]   n_root [LANES];

        if (j == 0) begin : g_first
            always_comb begin
                c_v    = i_valid;
                c_side = i_side;
                for (int l = 0; l < LANES; l++) begin
                    c_rad[l]  = i_rad[l];
                    c_rem[l]  = '0;
                    c_root[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                c_v    = r_v[j-1];
                c_side = r_side[j-1];
                for (int l = 0; l < LANES; l++) begin
                    c_rad[l]  = r_rad[j-1][l];
                    c_rem[l]  = r_rem[j-1][l];
                    c_root[l] = r_root[j-1][l];
                end
            end
        end

        // bring down two radicand bits, try root*4+1
        always_comb begin
            logic [RW+3:0] tr;
            logic [RW+3:0] trial;
            logic          ge;
            for (int l = 0; l < LANES; l++) begin
                tr        = {c_rem[l], c_rad[l][2*RW-1:2*RW-2]};
                trial     = {2'b00, c_root[l], 2'b01};
                ge        = (tr >= trial);
                n_rem[l]  = ge ? (RW+2)'(tr - trial) : tr[RW+1:0];
                n_root[l] = {c_root[l][RW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= c_side;
                for (int l = 0; l < LANES; l++) begin
                    r_rad[j][l]  <= {c_rad[l][2*RW-3:0], 2'b00};
                    r_rem[j][l]  <= n_rem[l];
                    r_root[j][l] <= n_root[l];
                end
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_side  = r_side[RW-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[RW-1][l];
            o_rem[l]  = r_rem[RW-1][l];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/video_grid_resize_calc.sv
// ============================================================================
// video_grid_resize_calc
// Patch grid resize: rounds a clip's sides to factor multiples and rescales
// them so that frames times height times width stays within the bounds.
// ============================================================================
// Throughput: one word per cycle; the divider and square root cell rows
//   advance together. A stalled output word parks the next word in a skid
//   register, and only a full skid register holds the pipeline and the input.
// Reset: synchronous, active low; clears all valid bits and loads the
//   configuration reset values. No clearing pass.
`default_nettype none

module video_grid_resize_calc #(
    parameter int MAX_SIDE   = vgrc_pkg::DEF_MAX_SIDE,
    parameter int FRAME_CAP  = vgrc_pkg::DEF_FRAME_CAP
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [vgrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vgrc_pkg::VOL_W-1:0]      i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [vgrc_pkg::N_W-1:0]        i_frame_count,
    input  logic [vgrc_pkg::SIDE_W-1:0]     i_in_height,
    input  logic [vgrc_pkg::SIDE_W-1:0]     i_in_width,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [vgrc_pkg::OUT_W-1:0]      o_out_height,
    output logic [vgrc_pkg::OUT_W-1:0]      o_out_width,
    output logic [1:0]                      o_status
);

    import vgrc_pkg::*;

    localparam int HEAD_W = $bits(t_head);
    localparam int TAIL_W = $bits(t_tail);

    // ------------------------------------------------------------------
    // Configuration registers; the user must write them only while the pipe
    // is empty, not enforced here, so every stage reads them directly.
    // ------------------------------------------------------------------
    logic [F_W-1:0]   r_cfg_f;
    logic [TF_W-1:0]  r_cfg_tf;
    logic [VOL_W-1:0] r_cfg_min;
    logic [VOL_W-1:0] r_cfg_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_f   <= RST_SPATIAL;
            r_cfg_tf  <= RST_TEMPORAL;
            r_cfg_min <= RST_MIN_VOL;
            r_cfg_max <= RST_MAX_VOL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SPATIAL:  r_cfg_f   <= i_cfg_data[F_W-1:0];
                CFG_TEMPORAL: r_cfg_tf  <= i_cfg_data[TF_W-1:0];
                CFG_MIN_VOL:  r_cfg_min <= i_cfg_data;
                CFG_MAX_VOL:  r_cfg_max <= i_cfg_data;
            endcase
        end
    end

    // a zero factor acts as one
    logic [F_W-1:0]  f_eff;
    logic [TF_W-1:0] tf_eff;
    assign f_eff  = (r_cfg_f == '0)  ? F_W'(1)  : r_cfg_f;
    assign tf_eff = (r_cfg_tf == '0) ? TF_W'(1) : r_cfg_tf;

    // ------------------------------------------------------------------
    // Global advance: every stage moves while the skid register is empty,
    // so the input stall comes straight from a register.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_skid_v;
    logic adv;
    assign adv        = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // ------------------------------------------------------------------
    // Stage 0: saturate the fields, reject small sides and wild aspect.
    // ------------------------------------------------------------------
    logic  r_s0_v;
    t_head r_s0;
    t_head n_s0;

    always_comb begin
        logic [SIDE_W-1:0] big;
        logic [SIDE_W-1:0] sml;
        logic [21:0]       lim;
        n_s0 = '0;
        if (i_frame_count == '0) begin
            n_s0.n = N_W'(1);
        end else if (32'(i_frame_count) > FRAME_CAP) begin
            n_s0.n = N_W'(FRAME_CAP);
        end else begin
            n_s0.n = i_frame_count;
        end
        n_s0.h = (32'(i_in_height) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : i_in_height;
        n_s0.w = (32'(i_in_width) > MAX_SIDE)  ? SIDE_W'(MAX_SIDE) : i_in_width;
        big = (n_s0.h > n_s0.w) ? n_s0.h : n_s0.w;
        sml = (n_s0.h > n_s0.w) ? n_s0.w : n_s0.h;
        lim = 22'(sml) * 22'(ASPECT_LIMIT);
        priority if (n_s0.h < SIDE_W'(f_eff) || n_s0.w < SIDE_W'(f_eff)) begin
            n_s0.status = ST_SMALL;
        end else if (22'(big) > lim) begin
            n_s0.status = ST_ASPECT;
        end else begin
            n_s0.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (adv) begin
            r_s0_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0 <= n_s0;
        end
    end

    // ------------------------------------------------------------------
    // Chain A: h/f, w/f, n/tf and 65535/f, 16 cells.
    // ------------------------------------------------------------------
    logic              a_v;
    logic [15:0]       a_num [4];
    logic [F_W-1:0]    a_den [4];
    logic [15:0]       a_quo [4];
    logic [F_W-1:0]    a_rem [4];
    logic [HEAD_W-1:0] a_side;
    t_head             a_head;

    always_comb begin
        a_num[0] = 16'(r_s0.h);
        a_num[1] = 16'(r_s0.w);
        a_num[2] = 16'(r_s0.n);
        a_num[3] = 16'hFFFF;
        a_den[0] = f_eff;
        a_den[1] = f_eff;
        a_den[2] = F_W'(tf_eff);
        a_den[3] = f_eff;
    end

    vgrc_div_chain #(
        .LANES (4),
        .NW    (16),
        .DW    (F_W),
        .SW    (HEAD_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s0_v),
        .i_num   (a_num),
        .i_den   (a_den),
        .i_side  (r_s0),
        .o_valid (a_v),
        .o_quo   (a_quo),
        .o_rem   (a_rem),
        .o_side  (a_side)
    );

    assign a_head = t_head'(a_side);

    // ------------------------------------------------------------------
    // Stages B1..B4: round to even, round frames up, build the volume
    // and pick the rescale direction.
    // ------------------------------------------------------------------
    logic r_b1_v, r_b2_v, r_b3_v, r_b4_v;
    t_mid r_b1, r_b2, r_b3, r_b4;
    t_mid n_b1, n_b2, n_b3, n_b4;

    always_comb begin
        logic [14:0] qh, qw;
        logic        ih, iw;
        logic [25:0] ph, pw;
        logic [13:0] tq;
        logic [18:0] pt;
        logic [26:0] ps;
        n_b1        = '0;
        n_b1.status = a_head.status;
        n_b1.n      = a_head.n;
        n_b1.h      = a_head.h;
        n_b1.w      = a_head.w;
        // nearest multiple, halfway goes to the even quotient
        ih = ({a_rem[0], 1'b0} > {1'b0, f_eff}) ||
             (({a_rem[0], 1'b0} == {1'b0, f_eff}) && a_quo[0][0]);
        iw = ({a_rem[1], 1'b0} > {1'b0, f_eff}) ||
             (({a_rem[1], 1'b0} == {1'b0, f_eff}) && a_quo[1][0]);
        qh = a_quo[0][14:0] + 15'(ih);
        qw = a_quo[1][14:0] + 15'(iw);
        ph = 26'(qh) * 26'(f_eff);
        pw = 26'(qw) * 26'(f_eff);
        n_b1.hr = ph[14:0];
        n_b1.wr = pw[14:0];
        // frames round up
        tq = a_quo[2][13:0] + 14'(a_rem[2] != '0);
        pt = 19'(tq) * 19'(tf_eff);
        n_b1.t = pt[13:0];
        // largest factor multiple that fits the output field
        ps = 27'(a_quo[3]) * 27'(f_eff);
        n_b1.satv = ps[15:0];
        n_b1.nw = 27'(a_head.n) * 27'(a_head.w);
        n_b1.nh = 27'(a_head.n) * 27'(a_head.h);
    end

    always_comb begin
        n_b2    = r_b1;
        n_b2.th = 29'(r_b1.t) * 29'(r_b1.hr);
    end

    always_comb begin
        n_b3     = r_b2;
        n_b3.vol = 44'(r_b2.th) * 44'(r_b2.wr);
    end

    always_comb begin
        n_b4        = r_b3;
        n_b4.shrink = (r_b3.vol > 44'(r_cfg_max));
        n_b4.grow   = !n_b4.shrink && (r_b3.vol < 44'(r_cfg_min));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
        end else if (adv) begin
            r_b1_v <= a_v;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= n_b3;
            r_b4 <= n_b4;
        end
    end

    // ------------------------------------------------------------------
    // Chain C: side*bound / (n*other side), 46 cells, both sides at once.
    // ------------------------------------------------------------------
    logic [VOL_W-1:0]  vsel;
    logic [45:0]       c_num [2];
    logic [26:0]       c_den [2];
    logic [45:0]       c_quo [2];
    logic [26:0]       c_rem [2];
    logic              c_v;
    logic [TAIL_W-1:0] c_side;
    t_tail             b4_tail;
    t_tail             c_tail;

    assign vsel = r_b4.shrink ? r_cfg_max : r_cfg_min;

    always_comb begin
        c_num[0] = 46'(r_b4.h) * 46'(vsel);
        c_num[1] = 46'(r_b4.w) * 46'(vsel);
        c_den[0] = r_b4.nw;
        c_den[1] = r_b4.nh;
        b4_tail.status = r_b4.status;
        b4_tail.shrink = r_b4.shrink;
        b4_tail.grow   = r_b4.grow;
        b4_tail.hr     = r_b4.hr;
        b4_tail.wr     = r_b4.wr;
        b4_tail.satv   = r_b4.satv;
    end

    vgrc_div_chain #(
        .LANES (2),
        .NW    (46),
        .DW    (27),
        .SW    (TAIL_W)
    ) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_b4_v),
        .i_num   (c_num),
        .i_den   (c_den),
        .i_side  (b4_tail),
        .o_valid (c_v),
        .o_quo   (c_quo),
        .o_rem   (c_rem),
        .o_side  (c_side)
    );

    assign c_tail = t_tail'(c_side);

    // ------------------------------------------------------------------
    // Chain D: square root, 24 cells. Growing takes the ceiling quotient.
    // ------------------------------------------------------------------
    logic [47:0]       d_rad  [2];
    logic [23:0]       d_root [2];
    logic [25:0]       d_rem  [2];
    logic              d_v;
    logic [TAIL_W-1:0] d_side;
    t_tail             d_tail;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            d_rad[l] = 48'(c_quo[l]) + 48'(c_tail.grow && (c_rem[l] != '0));
        end
    end

    vgrc_sqrt_chain #(
        .LANES (2),
        .RW    (24),
        .SW    (TAIL_W)
    ) u_sqrt_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (c_v),
        .i_rad   (d_rad),
        .i_side  (c_side),
        .o_valid (d_v),
        .o_root  (d_root),
        .o_rem   (d_rem),
        .o_side  (d_side)
    );

    assign d_tail = t_tail'(d_side);

    // ------------------------------------------------------------------
    // Chain E: root / f, 25 cells. Growing takes the ceiling root.
    // ------------------------------------------------------------------
    logic [24:0]       e_num [2];
    logic [F_W-1:0]    e_den [2];
    logic [24:0]       e_quo [2];
    logic [F_W-1:0]    e_rem [2];
    logic              e_v;
    logic [TAIL_W-1:0] e_side;
    t_tail             e_tail;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            e_num[l] = 25'(d_root[l]) + 25'(d_tail.grow && (d_rem[l] != '0));
            e_den[l] = f_eff;
        end
    end

    vgrc_div_chain #(
        .LANES (2),
        .NW    (25),
        .DW    (F_W),
        .SW    (TAIL_W)
    ) u_div_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (d_v),
        .i_num   (e_num),
        .i_den   (e_den),
        .i_side  (d_side),
        .o_valid (e_v),
        .o_quo   (e_quo),
        .o_rem   (e_rem),
        .o_side  (e_side)
    );

    assign e_tail = t_tail'(e_side);

    // ------------------------------------------------------------------
    // Stage F: multiple count back to pixels.
    // ------------------------------------------------------------------
    logic        r_f_v;
    t_tail       r_f_tail;
    logic [36:0] r_f_side [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (adv) begin
            r_f_v <= e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [25:0] k;
        if (adv) begin
            r_f_tail <= e_tail;
            for (int l = 0; l < 2; l++) begin
                k = 26'(e_quo[l]) + 26'(e_tail.grow && (e_rem[l] != '0));
                r_f_side[l] <= 37'(k) * 37'(f_eff);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor shrink at f, saturate to the field, zero
    // both sides on a rejected word. While the output word is held, park
    // the next word in the skid register; move it up once the hold ends.
    // ------------------------------------------------------------------
    logic [OUT_W-1:0] r_out_side [2];
    t_status          r_out_status;
    logic [OUT_W-1:0] r_skid_side [2];
    t_status          r_skid_status;
    logic [OUT_W-1:0] n_out_side [2];
    logic             out_hold;

    assign out_hold = r_out_valid && i_out_stall;

    always_comb begin
        logic [36:0] cand;
        for (int l = 0; l < 2; l++) begin
            if (r_f_tail.shrink || r_f_tail.grow) begin
                cand = (r_f_tail.shrink && (r_f_side[l] == '0)) ? 37'(f_eff) : r_f_side[l];
            end else begin
                cand = (l == 0) ? 37'(r_f_tail.hr) : 37'(r_f_tail.wr);
            end
            if (r_f_tail.status != ST_OK) begin
                n_out_side[l] = '0;
            end else if (cand > 37'(16'hFFFF)) begin
                n_out_side[l] = r_f_tail.satv;
            end else begin
                n_out_side[l] = cand[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_v    <= 1'b0;
        end else if (r_skid_v) begin
            // output stays valid: the parked word moves up when taken
            if (!i_out_stall) begin
                r_skid_v <= 1'b0;
            end
        end else if (out_hold) begin
            r_skid_v <= r_f_v;
        end else begin
            r_out_valid <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (!i_out_stall) begin
                r_out_side[0] <= r_skid_side[0];
                r_out_side[1] <= r_skid_side[1];
                r_out_status  <= r_skid_status;
            end
        end else if (out_hold) begin
            r_skid_side[0] <= n_out_side[0];
            r_skid_side[1] <= n_out_side[1];
            r_skid_status  <= r_f_tail.status;
        end else begin
            r_out_side[0] <= n_out_side[0];
            r_out_side[1] <= n_out_side[1];
            r_out_status  <= r_f_tail.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_height = r_out_side[0];
    assign o_out_width  = r_out_side[1];
    assign o_status     = r_out_status;

`ifndef ASSERT_OFF
    // a rejected word carries zero sides
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_out_height == '0 && o_out_width == '0))
        else $error("rejected word with nonzero sides");

    // an accepted word never has a zero side
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |-> (o_out_height != '0 && o_out_width != '0))
        else $error("good word with a zero side");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
